>>> design/lsda_call_site_lookup_macros.svh
// Assertion macros for the call-site lookup block.
// Used by the port checker; expects i_clk and i_rst_n in the enclosing scope.
`ifndef LSDA_CALL_SITE_LOOKUP_MACROS_SVH
`define LSDA_CALL_SITE_LOOKUP_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define LCSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A signal holds its value in the cycle after a condition.
`define LCSL_ASSERT_HOLD(label, cond, sig, msg) \
    `LCSL_ASSERT(label, (cond) |=> $stable(sig), msg)

`endif

>>> design/lcsl_pkg.sv
// Shared types and constants of the LSDA call-site lookup block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package lcsl_pkg;

    localparam int ADDR_W = 64;
    localparam logic [63:0] ADDR_MASK =
        (ADDR_W >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_W) - 64'd1);

    localparam logic [7:0] ENC_OMIT      = 8'hFF;
    localparam logic [7:0] LEB_DATA_MASK = 8'h7f;
    localparam logic [7:0] LEB_CONT      = 8'h80;
    localparam logic [7:0] ABI_VERSION   = 8'd1;
    localparam logic [6:0] LEB_SHIFT_STEP = 7'd7;
    localparam logic [6:0] LEB_SHIFT_MAX  = 7'd70;

    localparam int ACT_SEARCH  = 0;
    localparam int ACT_CLEANUP = 1;
    localparam int ACT_HANDLER = 2;

    typedef enum logic {
        OP_START = 1'b0,
        OP_BYTE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        V_CONTINUE = 2'd0,
        V_HANDLER  = 2'd1,
        V_INSTALL  = 2'd2,
        V_FATAL    = 2'd3
    } t_verdict;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LP_ENC,
        PH_LP_VAL,
        PH_TT_ENC,
        PH_TT_VAL,
        PH_CS_ENC,
        PH_CS_LEN,
        PH_RECORD
    } t_phase;

    typedef enum logic [1:0] {
        FLD_START,
        FLD_LENGTH,
        FLD_PAD,
        FLD_ACTION
    } t_field;

    typedef struct packed {
        t_op         operation;
        logic [7:0]  data_byte;
        logic [63:0] return_address;
        logic [63:0] region_start;
        logic [2:0]  action_flags;
        logic [7:0]  abi_version;
        logic        has_lsda;
        logic [63:0] exception_ref;
    } t_in_word;

    typedef struct packed {
        t_verdict    verdict;
        logic [63:0] landing_pad;
        logic        selector_value;
        logic [63:0] exception_value;
    } t_out_word;

    typedef struct packed {
        logic feed;
        logic clear;
    } t_leb_ctrl;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } t_leb_stat;

endpackage

`default_nettype wire

>>> design/lsda_call_site_lookup.sv
// Top level of the LSDA call-site lookup: input register, parser, result register.
// Depends on lcsl_pkg and lcsl_site_parser.
//
//   Channel | Direction | Handshake                  | Word
//   --------+-----------+----------------------------+-----------
//   in      | to block  | i_in_valid / o_in_stall    | i_in_word
//   out     | from block| o_out_valid / i_out_stall  | o_out_word
//
// One word is taken every cycle while o_in_stall is low; the result of a word passes
// through the input register, then the result register, to the out channel.
// Each LSDA byte is decoded and compared combinationally between those registers.
// Reset closes any open lookup; bytes that arrive while no lookup is open give no word.
// While a result waits under i_out_stall, a valid word in the input register holds and
// o_in_stall goes high.
`default_nettype none

module lsda_call_site_lookup (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lcsl_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lcsl_pkg::t_out_word o_out_word
);
    import lcsl_pkg::*;

    logic      r_in_vld;
    t_in_word  r_in_word;
    logic      r_out_vld;
    t_out_word r_out_word;

    logic      w_out_free;
    logic      w_go;
    logic      w_res_vld;
    t_out_word w_res;

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_go       = r_in_vld && w_out_free;
    assign o_in_stall = r_in_vld && !w_out_free;

    lcsl_site_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_go),
        .i_word    (r_in_word),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_go && w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_res_vld) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

>>> design/lcsl_leb_decoder.sv
// ULEB128 decoder: accumulates seven payload bits per byte fed.
// Depends on lcsl_pkg.
`default_nettype none

module lcsl_leb_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcsl_pkg::t_leb_ctrl i_ctrl,
    input  logic [7:0]          i_byte,
    output lcsl_pkg::t_leb_stat o_stat
);
    import lcsl_pkg::*;

    logic [63:0] r_acc, n_acc;
    logic [6:0]  r_shift, n_shift;
    logic [63:0] w_bits;
    logic [63:0] w_merged;
    logic        w_last;

    // Payload bits shifted to position 64 or beyond fall off the word.
    assign w_bits   = {56'd0, (i_byte & LEB_DATA_MASK)} << r_shift;
    assign w_merged = r_acc | w_bits;
    assign w_last   = ((i_byte & LEB_CONT) == 8'd0);

    always_comb begin
        n_acc   = r_acc;
        n_shift = r_shift;
        priority if (i_ctrl.clear) begin
            n_acc   = 64'd0;
            n_shift = 7'd0;
        end else if (i_ctrl.feed) begin
            if (w_last) begin
                n_acc   = 64'd0;
                n_shift = 7'd0;
            end else begin
                n_acc   = w_merged;
                n_shift = (r_shift < LEB_SHIFT_MAX) ? r_shift + LEB_SHIFT_STEP : r_shift;
            end
        end else begin
            // Nothing fed this cycle: the partial value holds.
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 64'd0;
            r_shift <= 7'd0;
        end else begin
            r_acc   <= n_acc;
            r_shift <= n_shift;
        end
    end

    assign o_stat.done  = i_ctrl.feed & ~i_ctrl.clear & w_last;
    assign o_stat.value = w_merged & ADDR_MASK;

endmodule

`default_nettype wire

>>> design/lcsl_site_parser.sv
// Header parser and call-site record scanner; produces the lookup verdict.
// Depends on lcsl_pkg and lcsl_leb_decoder.
`default_nettype none

module lcsl_site_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  lcsl_pkg::t_in_word  i_word,
    output logic                o_res_vld,
    output lcsl_pkg::t_out_word o_res
);
    import lcsl_pkg::*;

    t_phase      r_phase, n_phase;
    t_field      r_fidx, n_fidx;
    logic [63:0] r_ip_offset, n_ip_offset;
    logic [63:0] r_base, n_base;
    logic [2:0]  r_actions, n_actions;
    logic [63:0] r_exc, n_exc;
    logic [63:0] r_left, n_left;
    logic [63:0] r_site_start, n_site_start;
    logic [63:0] r_pad_sum, n_pad_sum;
    logic        r_pad_zero, n_pad_zero;
    logic        r_before, n_before;
    logic        r_inside, n_inside;

    t_leb_ctrl   w_leb_ctrl;
    t_leb_stat   w_leb_stat;
    logic [63:0] w_left_dec;
    logic        w_act_nz;
    logic        w_judged;

    function automatic t_out_word make_result(t_verdict v, logic [63:0] pad, logic sel,
                                              logic [63:0] exc);
        t_out_word res;
        res.verdict         = v;
        res.landing_pad     = pad;
        res.selector_value  = sel;
        res.exception_value = exc;
        return res;
    endfunction

    lcsl_leb_decoder u_leb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_leb_ctrl),
        .i_byte  (i_word.data_byte),
        .o_stat  (w_leb_stat)
    );

    assign w_left_dec = r_left - {63'd0, (r_left != 64'd0)};
    assign w_act_nz   = (w_leb_stat.value != 64'd0);

    always_comb begin
        n_phase      = r_phase;
        n_fidx       = r_fidx;
        n_ip_offset  = r_ip_offset;
        n_base       = r_base;
        n_actions    = r_actions;
        n_exc        = r_exc;
        n_left       = r_left;
        n_site_start = r_site_start;
        n_pad_sum    = r_pad_sum;
        n_pad_zero   = r_pad_zero;
        n_before     = r_before;
        n_inside     = r_inside;
        w_leb_ctrl   = '0;
        w_judged     = 1'b0;
        o_res_vld    = 1'b0;
        o_res        = make_result(V_CONTINUE, 64'd0, 1'b0, 64'd0);

        if (i_go && (i_word.operation == OP_START)) begin
            w_leb_ctrl.clear = 1'b1;
            n_fidx           = FLD_START;
            n_left           = 64'd0;
            priority if (i_word.abi_version != ABI_VERSION) begin
                o_res_vld = 1'b1;
                o_res     = make_result(V_FATAL, 64'd0, 1'b0, 64'd0);
                n_phase   = PH_IDLE;
            end else if (!i_word.has_lsda) begin
                o_res_vld = 1'b1;
                n_phase   = PH_IDLE;
            end else begin
                n_ip_offset = ((i_word.return_address & ADDR_MASK) - 64'd1
                               - (i_word.region_start & ADDR_MASK)) & ADDR_MASK;
                n_base      = i_word.region_start & ADDR_MASK;
                n_actions   = i_word.action_flags;
                n_exc       = i_word.exception_ref & ADDR_MASK;
                n_phase     = PH_LP_ENC;
            end
        end else if (i_go) begin
            unique case (r_phase)
                PH_IDLE: begin
                    // Bytes after a verdict are dropped.
                end
                PH_LP_ENC: begin
                    n_phase = (i_word.data_byte == ENC_OMIT) ? PH_TT_ENC : PH_LP_VAL;
                end
                PH_LP_VAL: begin
                    w_leb_ctrl.feed = 1'b1;
                    if (w_leb_stat.done) begin
                        n_base  = w_leb_stat.value;
                        n_phase = PH_TT_ENC;
                    end
                end
                PH_TT_ENC: begin
                    n_phase = (i_word.data_byte == ENC_OMIT) ? PH_CS_ENC : PH_TT_VAL;
                end
                PH_TT_VAL: begin
                    w_leb_ctrl.feed = 1'b1;
                    if (w_leb_stat.done) begin
                        n_phase = PH_CS_ENC;
                    end
                end
                PH_CS_ENC: begin
                    n_phase = PH_CS_LEN;
                end
                PH_CS_LEN: begin
                    w_leb_ctrl.feed = 1'b1;
                    if (w_leb_stat.done) begin
                        n_left = w_leb_stat.value;
                        n_fidx = FLD_START;
                        if (w_leb_stat.value == 64'd0) begin
                            o_res_vld = 1'b1;
                            n_phase   = PH_IDLE;
                        end else begin
                            n_phase = PH_RECORD;
                        end
                    end
                end
                PH_RECORD: begin
                    n_left          = w_left_dec;
                    w_leb_ctrl.feed = 1'b1;
                    if (w_leb_stat.done) begin
                        // Coverage compares are done as each field lands, so the
                        // action byte only has to pick the verdict.
                        unique case (r_fidx)
                            FLD_START: begin
                                n_site_start = w_leb_stat.value;
                                n_before     = (r_ip_offset < w_leb_stat.value);
                                n_fidx       = FLD_LENGTH;
                            end
                            FLD_LENGTH: begin
                                n_inside = (r_ip_offset <
                                            ((r_site_start + w_leb_stat.value) & ADDR_MASK));
                                n_fidx   = FLD_PAD;
                            end
                            FLD_PAD: begin
                                n_pad_zero = (w_leb_stat.value == 64'd0);
                                n_pad_sum  = (r_base + w_leb_stat.value) & ADDR_MASK;
                                n_fidx     = FLD_ACTION;
                            end
                            FLD_ACTION: begin
                                n_fidx = FLD_START;
                                if (r_before) begin
                                    w_judged = 1'b1;
                                end else if (r_inside) begin
                                    priority if (r_pad_zero) begin
                                        w_judged = 1'b1;
                                    end else if (r_actions[ACT_SEARCH]) begin
                                        w_judged = 1'b1;
                                        o_res    = make_result(w_act_nz ? V_HANDLER : V_CONTINUE,
                                                               64'd0, 1'b0, 64'd0);
                                    end else if (r_actions[ACT_CLEANUP]) begin
                                        w_judged = 1'b1;
                                        priority if (r_actions[ACT_HANDLER]) begin
                                            o_res = make_result(V_INSTALL, r_pad_sum,
                                                                w_act_nz, r_exc);
                                        end else if (!w_act_nz) begin
                                            o_res = make_result(V_INSTALL, r_pad_sum,
                                                                1'b0, r_exc);
                                        end else begin
                                            o_res = make_result(V_CONTINUE, 64'd0,
                                                                1'b0, 64'd0);
                                        end
                                    end else begin
                                        // Neither phase flag: keep scanning.
                                        w_judged = 1'b0;
                                    end
                                end
                                if (w_judged || (w_left_dec == 64'd0)) begin
                                    o_res_vld = 1'b1;
                                    n_phase   = PH_IDLE;
                                end
                            end
                            default: begin
                                n_fidx = FLD_START;
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_fidx       <= FLD_START;
            r_ip_offset  <= 64'd0;
            r_base       <= 64'd0;
            r_actions    <= 3'd0;
            r_exc        <= 64'd0;
            r_left       <= 64'd0;
            r_site_start <= 64'd0;
            r_pad_sum    <= 64'd0;
            r_pad_zero   <= 1'b0;
            r_before     <= 1'b0;
            r_inside     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_fidx       <= n_fidx;
            r_ip_offset  <= n_ip_offset;
            r_base       <= n_base;
            r_actions    <= n_actions;
            r_exc        <= n_exc;
            r_left       <= n_left;
            r_site_start <= n_site_start;
            r_pad_sum    <= n_pad_sum;
            r_pad_zero   <= n_pad_zero;
            r_before     <= n_before;
            r_inside     <= n_inside;
        end
    end

endmodule

`default_nettype wire

>>> design/lcsl_checker.sv
// Port-level checker for the LSDA call-site lookup, bound to the top level.
// Depends on lcsl_pkg and lsda_call_site_lookup_macros.svh.
`default_nettype none

`include "lsda_call_site_lookup_macros.svh"

module lcsl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input lcsl_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lcsl_pkg::t_out_word o_out_word
);
    import lcsl_pkg::*;

    // A waiting result word must not change.
    `LCSL_ASSERT_HOLD(a_out_hold, o_out_valid && i_out_stall, o_out_word, "out word changed while stalled")

    // The block only pushes back when its result register is full and stalled.
    `LCSL_ASSERT(a_stall_cause, o_in_stall |-> (o_out_valid && i_out_stall), "in stall without out stall")

    // Only an install carries a landing pad, selector and exception value.
    `LCSL_ASSERT(a_unused_zero, (o_out_valid && (o_out_word.verdict != V_INSTALL)) |-> ((o_out_word.landing_pad == 64'd0) && (o_out_word.selector_value == 1'b0) && (o_out_word.exception_value == 64'd0)), "unused result fields not zero")

    // A start word with a bad version answers fatal once the result register frees up.
    `LCSL_ASSERT(a_fatal_version, (i_in_valid && !o_in_stall && (i_in_word.operation == OP_START) && (i_in_word.abi_version != ABI_VERSION)) ##1 (!o_out_valid || !i_out_stall) |=> (o_out_valid && (o_out_word.verdict == V_FATAL)), "bad version did not give fatal")

endmodule

bind lsda_call_site_lookup lcsl_checker u_lcsl_checker (.*);

`default_nettype wire

>>> tb/sv/lcsl_verdict_checker.sv
`timescale 1ns / 1ps
// Checker for the LSDA call-site lookup: it watches both channels, predicts the verdict
// of every lookup and compares each result word with it. Depends on lcsl_pkg.
module lcsl_verdict_checker
    import lcsl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    // Shadow copy of the lookup state.
    t_phase      phase;
    t_field      field_idx;
    logic [63:0] leb_acc;
    logic [6:0]  leb_shift;
    logic [63:0] lp_base;
    logic [63:0] table_left;
    logic [63:0] frame_offset;
    logic [2:0]  saved_flags;
    logic [63:0] site_start;
    logic [63:0] site_len;
    logic [63:0] site_pad;
    logic [63:0] saved_exc;

    t_out_word   verdicts_due[$];
    int          fail_total = 0;
    int          pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    task automatic clear_lookup_state();
        phase        = PH_IDLE;
        field_idx    = FLD_START;
        leb_acc      = '0;
        leb_shift    = '0;
        lp_base      = '0;
        table_left   = '0;
        frame_offset = '0;
        saved_flags  = '0;
        site_start   = '0;
        site_len     = '0;
        site_pad     = '0;
        saved_exc    = '0;
    endtask

    task automatic note_failure(input string msg);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic post_verdict(input t_verdict v, input logic [63:0] pad, input logic sel,
                                input logic [63:0] exc);
        t_out_word r;
        r.verdict         = v;
        r.landing_pad     = pad;
        r.selector_value  = sel;
        r.exception_value = exc;
        verdicts_due.push_back(r);
        phase = PH_IDLE;
    endtask

    // Payload bits past position 63 fall off; the shift saturates so it cannot wrap.
    task automatic feed_uleb(input logic [7:0] b, output logic done, output logic [63:0] value);
        if (leb_shift < 7'd64) begin
            leb_acc = leb_acc | ({56'd0, b & LEB_DATA_MASK} << leb_shift);
        end
        if (leb_shift < LEB_SHIFT_MAX) begin
            leb_shift = leb_shift + LEB_SHIFT_STEP;
        end
        done  = (b & LEB_CONT) == 8'd0;
        value = leb_acc & ADDR_MASK;
        if (done) begin
            leb_acc   = '0;
            leb_shift = '0;
        end
    endtask

    task automatic judge_site(input logic [63:0] action, output logic given);
        logic [63:0] pad;
        given = 1'b1;
        pad   = (lp_base + site_pad) & ADDR_MASK;
        if (frame_offset < site_start) begin
            post_verdict(V_CONTINUE, '0, 1'b0, '0);
        end else if (frame_offset < ((site_start + site_len) & ADDR_MASK)) begin
            if (site_pad == '0) begin
                post_verdict(V_CONTINUE, '0, 1'b0, '0);
            end else if (saved_flags[ACT_SEARCH]) begin
                post_verdict((action != '0) ? V_HANDLER : V_CONTINUE, '0, 1'b0, '0);
            end else if (saved_flags[ACT_CLEANUP]) begin
                if (saved_flags[ACT_HANDLER]) begin
                    post_verdict(V_INSTALL, pad, action != '0, saved_exc);
                end else if (action != '0) begin
                    post_verdict(V_CONTINUE, '0, 1'b0, '0);
                end else begin
                    post_verdict(V_INSTALL, pad, 1'b0, saved_exc);
                end
            end else begin
                // Neither phase flag: the scan moves on to the next record.
                given = 1'b0;
            end
        end else begin
            given = 1'b0;
        end
    endtask

    task automatic lookup_step(input t_in_word w);
        logic        done;
        logic        given;
        logic [63:0] v;
        if (w.operation == OP_START) begin
            leb_acc    = '0;
            leb_shift  = '0;
            field_idx  = FLD_START;
            table_left = '0;
            if (w.abi_version != ABI_VERSION) begin
                post_verdict(V_FATAL, '0, 1'b0, '0);
            end else if (!w.has_lsda) begin
                post_verdict(V_CONTINUE, '0, 1'b0, '0);
            end else begin
                frame_offset = ((w.return_address & ADDR_MASK) - 64'd1
                                - (w.region_start & ADDR_MASK)) & ADDR_MASK;
                lp_base      = w.region_start & ADDR_MASK;
                saved_flags  = w.action_flags;
                saved_exc    = w.exception_ref & ADDR_MASK;
                phase        = PH_LP_ENC;
            end
        end else begin
            case (phase)
                PH_LP_ENC: phase = (w.data_byte == ENC_OMIT) ? PH_TT_ENC : PH_LP_VAL;
                PH_LP_VAL: begin
                    feed_uleb(w.data_byte, done, v);
                    if (done) begin
                        lp_base = v;
                        phase   = PH_TT_ENC;
                    end
                end
                PH_TT_ENC: phase = (w.data_byte == ENC_OMIT) ? PH_CS_ENC : PH_TT_VAL;
                PH_TT_VAL: begin
                    feed_uleb(w.data_byte, done, v);
                    if (done) begin
                        phase = PH_CS_ENC;
                    end
                end
                PH_CS_ENC: phase = PH_CS_LEN;
                PH_CS_LEN: begin
                    feed_uleb(w.data_byte, done, v);
                    if (done) begin
                        table_left = v;
                        field_idx  = FLD_START;
                        if (v == '0) begin
                            post_verdict(V_CONTINUE, '0, 1'b0, '0);
                        end else begin
                            phase = PH_RECORD;
                        end
                    end
                end
                PH_RECORD: begin
                    if (table_left != '0) begin
                        table_left = table_left - 64'd1;
                    end
                    feed_uleb(w.data_byte, done, v);
                    if (done) begin
                        case (field_idx)
                            FLD_START: begin
                                site_start = v;
                                field_idx  = FLD_LENGTH;
                            end
                            FLD_LENGTH: begin
                                site_len  = v;
                                field_idx = FLD_PAD;
                            end
                            FLD_PAD: begin
                                site_pad  = v;
                                field_idx = FLD_ACTION;
                            end
                            default: begin
                                field_idx = FLD_START;
                                judge_site(v, given);
                                // The table end is only looked at between records.
                                if (!given && table_left == '0) begin
                                    post_verdict(V_CONTINUE, '0, 1'b0, '0);
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic check_verdict(input t_out_word got);
        t_out_word want;
        if (verdicts_due.size() == 0) begin
            note_failure($sformatf("unexpected word: verdict=%0d pad=%h sel=%0d exc=%h",
                                   got.verdict, got.landing_pad, got.selector_value,
                                   got.exception_value));
        end else begin
            want = verdicts_due.pop_front();
            if (got.verdict !== want.verdict || got.landing_pad !== want.landing_pad
                    || got.selector_value !== want.selector_value
                    || got.exception_value !== want.exception_value) begin
                note_failure($sformatf({"mismatch: expected verdict=%0d pad=%h sel=%0d exc=%h,",
                                        " got verdict=%0d pad=%h sel=%0d exc=%h"},
                                       want.verdict, want.landing_pad, want.selector_value,
                                       want.exception_value, got.verdict, got.landing_pad,
                                       got.selector_value, got.exception_value));
            end
        end
    endtask

    initial begin
        clear_lookup_state();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lookup_state();
            verdicts_due.delete();
        end else begin
            // A word taken now answers only through the input and result registers, so order is safe.
            if (i_out_valid && !i_out_stall) begin
                check_verdict(i_out_word);
            end
            if (i_in_valid && !i_in_stall) begin
                lookup_step(i_in_word);
            end
        end
        pending_total = verdicts_due.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the LSDA call-site lookup testbench: clock, reset, frame and LSDA byte stimulus
// and the final verdict. Depends on lcsl_pkg, lsda_call_site_lookup and lcsl_verdict_checker.
module testbench;
    import lcsl_pkg::*;

    localparam int ITEM_TARGET = 1650;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;

    int        fail_count;
    int        verdicts_pending;
    int        items_sent = 0;
    int        cycles = 0;
    logic      hold_req = 1'b0;
    logic      quiet = 1'b0;
    logic [7:0] lsda[$];

    lsda_call_site_lookup dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    lcsl_verdict_checker verdict_watch (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .o_fail_count(fail_count),
        .o_pending   (verdicts_pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_word noise_word();
        logic [255:0] bits;
        bits = {rand64(), rand64(), rand64(), rand64()};
        return t_in_word'(bits[$bits(t_in_word)-1:0]);
    endfunction

    function automatic t_in_word byte_word(input logic [7:0] b);
        t_in_word w;
        w           = noise_word();
        w.operation = OP_BYTE;
        w.data_byte = b;
        return w;
    endfunction

    function automatic t_in_word start_word(input logic [7:0] ver, input logic has,
                                            input logic [63:0] ra, input logic [63:0] rs,
                                            input logic [2:0] flags, input logic [63:0] exc);
        t_in_word w;
        w                = noise_word();
        w.operation      = OP_START;
        w.abi_version    = ver;
        w.has_lsda       = has;
        w.return_address = ra;
        w.region_start   = rs;
        w.action_flags   = flags;
        w.exception_ref  = exc;
        return w;
    endfunction

    // Mostly minimal encodings, some padded, a few running far past 64 bits.
    function automatic int leb_padding();
        int r;
        r = $urandom_range(0, 29);
        if (r == 0) return $urandom_range(5, 12);
        if (r < 4) return $urandom_range(1, 4);
        return 0;
    endfunction

    task automatic put_uleb(input logic [63:0] v, input int extra);
        int          groups;
        logic [63:0] rest;
        logic [6:0]  g;
        groups = 1;
        rest   = v >> 7;
        while (rest != '0) begin
            groups++;
            rest = rest >> 7;
        end
        groups += extra;
        for (int i = 0; i < groups; i++) begin
            if (i < 9) begin
                g = v[i*7 +: 7];
            end else if (i == 9) begin
                g = {6'($urandom), v[63]};
            end else begin
                g = 7'($urandom);
            end
            lsda.push_back({i < groups - 1, g});
        end
    endtask

    task automatic send_word(input t_in_word w);
        logic stalled;
        if (!quiet && $urandom_range(0, 99) < 34) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        // Inputs only move at rising edges, so the stall seen at the falling edge holds.
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        items_sent++;
    endtask

    task automatic send_bytes();
        foreach (lsda[i]) begin
            send_word(byte_word(lsda[i]));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (verdicts_pending != 0);
        @(posedge clk);
    endtask

    task automatic directed_words();
        send_word(byte_word(8'h5A));    // byte while no lookup is open
        send_word(start_word(8'd0, 1'b1, rand64(), rand64(), 3'b001, rand64()));
        send_word(start_word(8'hFF, 1'b1, '1, '1, 3'b111, '1));
        send_word(start_word(ABI_VERSION, 1'b0, '0, '0, 3'b000, '1));
        // Empty call-site table.
        send_word(start_word(ABI_VERSION, 1'b1, 64'd1, '0, 3'b001, rand64()));
        lsda = '{ENC_OMIT, ENC_OMIT, 8'h00, 8'h00};
        send_bytes();
        // A lookup abandoned by a new start.
        send_word(start_word(ABI_VERSION, 1'b1, '1, rand64(), 3'b010, rand64()));
        send_word(byte_word(ENC_OMIT));
        // Cleanup in a handler frame installs with a catch selector; a late byte is ignored.
        send_word(start_word(ABI_VERSION, 1'b1, 64'd1, '0, 3'b110, '1));
        lsda = '{ENC_OMIT, ENC_OMIT, 8'h00, 8'h04, 8'h00, 8'h01, 8'h05, 8'h01, 8'h80};
        send_bytes();
    endtask

    task automatic random_lookup();
        logic [63:0] base, off, pos, tlen;
        logic [63:0] st[4], ln[4], pd[4], ac[4];
        logic [7:0]  enc;
        logic [7:0]  rec[$];
        logic        wide;
        int          n, k, r;
        t_in_word    w;
        wide = ($urandom_range(0, 3) == 0);
        base = wide ? rand64() : 64'($urandom_range(0, 4096));
        n    = $urandom_range(1, 4);
        pos  = wide ? rand64() : 64'($urandom_range(0, 100));
        for (int i = 0; i < n; i++) begin
            st[i] = pos;
            if ($urandom_range(0, 3) != 0) begin
                st[i] = pos + (wide ? 64'($urandom) : 64'($urandom_range(1, 40)));
            end
            if (wide) begin
                ln[i] = ($urandom_range(0, 1) == 0) ? rand64() : 64'($urandom);
            end else begin
                ln[i] = 64'($urandom_range(0, 50));
            end
            pd[i] = '0;
            if ($urandom_range(0, 4) != 0) begin
                pd[i] = wide ? rand64() : 64'($urandom_range(1, 300));
            end
            ac[i] = '0;
            if ($urandom_range(0, 1) != 0) begin
                ac[i] = wide ? rand64() : 64'($urandom_range(1, 5));
            end
            pos = st[i] + ln[i];
        end
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 3))
            0, 1: off = st[k] + ((ln[k] == '0) ? '0 : rand64() % ln[k]);
            2: off = st[k] + ln[k] + 64'($urandom_range(0, 5));
            default: off = wide ? rand64() : 64'($urandom_range(0, 400));
        endcase

        w = start_word(($urandom_range(0, 19) == 0) ? 8'($urandom) : ABI_VERSION,
                       $urandom_range(0, 14) != 0, base + off + 64'd1, base,
                       3'($urandom), rand64());

        lsda.delete();
        for (int i = 0; i < n; i++) begin
            put_uleb(st[i], leb_padding());
            put_uleb(ln[i], leb_padding());
            put_uleb(pd[i], leb_padding());
            put_uleb(ac[i], leb_padding());
        end
        rec = lsda;
        lsda.delete();

        enc = ($urandom_range(0, 1) == 0) ? ENC_OMIT : 8'($urandom);
        lsda.push_back(enc);
        if (enc != ENC_OMIT) begin
            put_uleb(wide ? rand64() : 64'($urandom_range(0, 5000)), leb_padding());
        end
        enc = ($urandom_range(0, 1) == 0) ? ENC_OMIT : 8'($urandom);
        lsda.push_back(enc);
        if (enc != ENC_OMIT) begin
            put_uleb(wide ? rand64() : 64'($urandom_range(0, 300)), leb_padding());
        end
        lsda.push_back(8'($urandom));

        // A short length stops the scan after the record it falls in; a long one leaves it open.
        r = $urandom_range(0, 9);
        if (r == 0) tlen = '0;
        else if (r == 1) tlen = 64'($urandom_range(1, rec.size()));
        else if (r == 2) tlen = 64'(rec.size() + $urandom_range(1, 20));
        else tlen = 64'(rec.size());
        put_uleb(tlen, leb_padding());
        foreach (rec[i]) begin
            lsda.push_back(rec[i]);
        end
        repeat ($urandom_range(0, 3)) lsda.push_back(8'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(0, lsda.size() - 1);
            while (lsda.size() > r) void'(lsda.pop_back());
        end

        send_word(w);
        send_bytes();
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off on request.
    initial begin : receiver
        int   held;
        logic hold_now;
        logic calm;
        out_stall <= 1'b0;
        forever begin
            @(negedge clk);
            hold_now = hold_req;
            calm     = quiet;
            @(posedge clk);
            if (hold_now) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge clk);
                    held++;
                end
            end else begin
                out_stall <= !calm && ($urandom_range(0, 99) < 34);
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("** lsda_call_site_lookup: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic hold_done;
        logic drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        directed_words();
        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= 400) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_sent >= 800) begin
                wait_drained();
                drain_done = 1'b1;
            end
            quiet = (items_sent >= 1000 && items_sent < 1300);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) send_word(noise_word());
            end else begin
                random_lookup();
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && verdicts_pending == 0) begin
            $display("** lsda_call_site_lookup: PASSED **");
        end else begin
            $display("** lsda_call_site_lookup: FAILED **");
        end
        $finish;
    end

endmodule

>>> lsda_call_site_lookup.f
+incdir+design
design/lcsl_pkg.sv
design/lcsl_leb_decoder.sv
design/lcsl_site_parser.sv
design/lsda_call_site_lookup.sv
design/lcsl_checker.sv
tb/sv/lcsl_verdict_checker.sv
tb/sv/testbench.sv
